### hw/rtl/spatial_code_histogram_macros.svh
// Assertion macros for the spatial code histogram.
`ifndef SPATIAL_CODE_HISTOGRAM_MACROS_SVH
`define SPATIAL_CODE_HISTOGRAM_MACROS_SVH

// Same-cycle implication, off during reset.
`define SCH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sch: same-cycle check failed");

// Next-cycle implication, off during reset.
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sch: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define SCH_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sch: reset check failed");

`endif

### hw/rtl/sch_pkg.sv
package sch_pkg;

    localparam int NumBins  = 256;
    localparam int AddrW    = $clog2(NumBins);
    localparam int CountW   = 16;
    localparam int BinW     = 10;   // widest computed bin: 255 + 2*32 + 31
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;

    localparam logic [CountW-1:0] CountMax = '1;

    // request codes
    localparam logic ReqAccum = 1'b0;
    localparam logic ReqRead  = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgCodeCount  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgDivMode    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgMainSet    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCellWidth  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgCellHeight = 3'd4;

    typedef enum logic [2:0] {
        DivNone  = 3'd0,
        DivVert4 = 3'd1,
        DivHorz4 = 3'd2,
        DivVert2 = 3'd3,
        DivHorz2 = 3'd4,
        DivQuad  = 3'd5
    } t_div_mode;

    typedef struct packed {
        logic [7:0] code_count;
        logic [2:0] div_mode;
        logic [1:0] main_set;
        logic [7:0] cell_width;
        logic [7:0] cell_height;
    } t_cfg;

    typedef struct packed {
        logic             upd;      // bin exists and is touched
        logic             is_read;
        logic [AddrW-1:0] addr;
    } t_bin_op;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic [AddrW-1:0]  addr;
        logic [CountW-1:0] data;
    } t_bin_wr;

    // main code tables, padded with a code that never passes the range check
    localparam logic [7:0] MainTab [4][32] = '{
        '{8'd7, 8'd18, 8'd32, 8'd34, 8'd40, 8'd42, 8'd48, 8'd51,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'd2, 8'd7, 8'd10, 8'd13, 8'd16, 8'd18, 8'd24, 8'd26,
          8'd32, 8'd34, 8'd40, 8'd42, 8'd45, 8'd48, 8'd51, 8'd56,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'd1, 8'd2, 8'd7, 8'd8, 8'd10, 8'd13, 8'd15, 8'd16,
          8'd18, 8'd22, 8'd24, 8'd26, 8'd29, 8'd32, 8'd34, 8'd36,
          8'd40, 8'd42, 8'd43, 8'd45, 8'd48, 8'd50, 8'd51, 8'd56,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'd1, 8'd2, 8'd4, 8'd5, 8'd7, 8'd8, 8'd10, 8'd11,
          8'd13, 8'd15, 8'd16, 8'd18, 8'd21, 8'd22, 8'd24, 8'd26,
          8'd27, 8'd28, 8'd29, 8'd32, 8'd34, 8'd36, 8'd40, 8'd42,
          8'd43, 8'd45, 8'd47, 8'd48, 8'd50, 8'd51, 8'd53, 8'd56}
    };

    // {hit, position} of a code in the selected table
    function automatic logic [5:0] main_lookup(input logic [1:0] sel, input logic [7:0] code);
        logic       hit;
        logic [4:0] pos;
        hit = 1'b0;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (MainTab[sel][i] == code) begin
                hit = 1'b1;
                pos = 5'(i);
            end
        end
        return {hit, pos};
    endfunction

endpackage

### hw/rtl/sch_bin_map.sv
module sch_bin_map (
    input  sch_pkg::t_cfg    i_cfg,
    input  logic             i_req_type,
    input  logic [7:0]       i_code,
    input  logic [7:0]       i_col,
    input  logic [7:0]       i_row,
    input  logic [7:0]       i_idx,
    output sch_pkg::t_bin_op o_op,
    output logic [7:0]       o_hist_size
);
    import sch_pkg::*;

    logic [5:0]      k;
    logic [5:0]      lookup;
    logic            code_ok;
    logic            row_top;
    logic            col_left;
    logic [1:0]      rgn;
    logic [6:0]      off;
    logic [6:0]      span;
    logic [BinW-1:0] main_bin;
    logic [BinW-1:0] bin;
    logic [8:0]      hs_sum;

    function automatic logic [1:0] quarter_of(input logic [7:0] p, input logic [7:0] size);
        logic [8:0] q1;
        logic [8:0] q2;
        logic [8:0] q3;
        q1 = {3'b000, size[7:2]};
        q2 = {q1[7:0], 1'b0};
        q3 = q1 + q2;
        if ({1'b0, p} < q1) return 2'd0;
        if ({1'b0, p} < q2) return 2'd1;
        if ({1'b0, p} < q3) return 2'd2;
        return 2'd3;
    endfunction

    always_comb begin
        k        = {1'b0, i_cfg.main_set, 3'b000} + 6'd8;
        lookup   = main_lookup(i_cfg.main_set, i_code);
        code_ok  = i_code < i_cfg.code_count;
        row_top  = i_row < {1'b0, i_cfg.cell_height[7:1]};
        col_left = i_col < {1'b0, i_cfg.cell_width[7:1]};

        unique case (i_cfg.div_mode)
            DivVert4: rgn = quarter_of(i_row, i_cfg.cell_height);
            DivHorz4: rgn = quarter_of(i_col, i_cfg.cell_width);
            DivVert2: rgn = row_top ? 2'd0 : 2'd1;
            DivHorz2: rgn = col_left ? 2'd0 : 2'd1;
            DivQuad:  rgn = {!row_top, !col_left};
            default:  rgn = 2'd0;
        endcase

        // (region - 1) * K
        case (rgn)
            2'd2:    off = {1'b0, k};
            2'd3:    off = {k, 1'b0};
            default: off = '0;
        endcase

        main_bin = {2'b00, i_cfg.code_count} + {3'b000, off} + {5'b00000, lookup[4:0]};
        bin      = (lookup[5] && rgn != 2'd0) ? main_bin : {2'b00, i_code};

        unique case (i_cfg.div_mode) inside
            DivVert4, DivHorz4, DivQuad: span = {k, 1'b0} + {1'b0, k};
            DivVert2, DivHorz2:          span = {1'b0, k};
            default:                     span = '0;
        endcase
        hs_sum      = {1'b0, i_cfg.code_count} + {2'b00, span};
        o_hist_size = hs_sum[8] ? 8'hFF : hs_sum[7:0];

        if (i_req_type == ReqRead) begin
            o_op.is_read = 1'b1;
            o_op.upd     = {2'b00, i_idx} < BinW'(NumBins);
            o_op.addr    = i_idx[AddrW-1:0];
        end else begin
            o_op.is_read = 1'b0;
            o_op.upd     = code_ok && (bin < BinW'(NumBins));
            o_op.addr    = bin[AddrW-1:0];
        end
    end

endmodule

### hw/rtl/sch_bin_store.sv
module sch_bin_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [sch_pkg::AddrW-1:0]    i_rd_addr,
    input  sch_pkg::t_bin_wr             i_wr,
    output logic [sch_pkg::CountW-1:0]   o_old_count
);
    import sch_pkg::*;

    logic [CountW-1:0]  r_mem [NumBins];
    logic [NumBins-1:0] r_vld;          // entry holds a count; else reads zero
    logic [CountW-1:0]  r_rd_data;
    logic [CountW-1:0]  r_fwd_data;
    logic               r_rd_vld;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.clear) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.clear ? '0 : i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= !i_wr.clear;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                // same-cycle write to the bin being read: bypass
                r_fwd    <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    assign o_old_count = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

### hw/rtl/spatial_code_histogram.sv
// Spatial texture-code histogram for one image cell.
// Input channel (i_in_valid / o_in_stall): one request per accepted cycle.
//   Accumulate (req_type 0) adds one pixel code to its bin, chosen by code,
//   main-code table and the pixel's region; it produces no result.
//   Read (req_type 1) returns a bin's count with the histogram size and
//   clears that bin.
// Output channel (o_out_valid / i_out_stall): one result per read request.
// Config channel (i_cfg_valid / o_cfg_ready): ready is always high; write
//   registers only while no request is in flight.
// Throughput: one request per cycle while o_in_stall is low, set by the single
//   read-modify-write port of the bin memory; a bypass covers back-to-back hits on one bin.
// Path: an accepted read is registered in stage A, then in stage B, where
//   the memory data arrives, and then in the output register.
// Reset (synchronous, active low): all bins read as zero right away through
//   per-bin valid flags; no clearing pass. Registers go to their defaults.
// Stall: while a result waits on a stalled output and another read reaches
//   the update stage, the pipeline holds and o_in_stall rises if stage A
//   holds a request. Accumulate requests still drain.
module spatial_code_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_pixel_code,
    input  logic [7:0]                    i_col,
    input  logic [7:0]                    i_row,
    input  logic [7:0]                    i_bin_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sch_pkg::CountW-1:0]    o_bin_count,
    output logic [7:0]                    o_hist_size,
    // register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sch_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [sch_pkg::CfgDataW-1:0]  i_cfg_data
);
    import sch_pkg::*;

    t_cfg r_cfg;

    // stage A: input register
    logic        r_a_valid;
    logic        r_a_req;
    logic [7:0]  r_a_code;
    logic [7:0]  r_a_col;
    logic [7:0]  r_a_row;
    logic [7:0]  r_a_idx;

    // stage B: update stage, memory data arrives here
    logic        r_b_valid;
    t_bin_op     r_b_op;

    // output register
    logic              r_out_valid;
    logic [CountW-1:0] r_bin_count;
    logic [7:0]        r_hist_size;

    t_bin_op           map_op;
    logic [7:0]        map_hist_size;
    t_bin_wr           bin_wr;
    logic [CountW-1:0] old_count;
    logic              b_fire;
    logic              adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_count  <= 8'd72;
            r_cfg.div_mode    <= DivNone;
            r_cfg.main_set    <= 2'd1;
            r_cfg.cell_width  <= 8'd16;
            r_cfg.cell_height <= 8'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CfgCodeCount:  r_cfg.code_count  <= i_cfg_data;
                CfgDivMode:    r_cfg.div_mode    <= i_cfg_data[2:0];
                CfgMainSet:    r_cfg.main_set    <= i_cfg_data[1:0];
                CfgCellWidth:  r_cfg.cell_width  <= i_cfg_data;
                CfgCellHeight: r_cfg.cell_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // B finishes unless it is a read facing a full, stalled output
    assign b_fire     = r_b_valid && (!r_b_op.is_read || !r_out_valid || !i_out_stall);
    assign adv        = !r_b_valid || b_fire;
    assign o_in_stall = r_a_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_a_req  <= i_req_type;
            r_a_code <= i_pixel_code;
            r_a_col  <= i_col;
            r_a_row  <= i_row;
            r_a_idx  <= i_bin_index;
        end
    end

    sch_bin_map u_map (
        .i_cfg       (r_cfg),
        .i_req_type  (r_a_req),
        .i_code      (r_a_code),
        .i_col       (r_a_col),
        .i_row       (r_a_row),
        .i_idx       (r_a_idx),
        .o_op        (map_op),
        .o_hist_size (map_hist_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_op <= map_op;
        end
    end

    // saturating increment, or clear on read
    always_comb begin
        bin_wr.en    = b_fire && r_b_op.upd;
        bin_wr.clear = r_b_op.is_read;
        bin_wr.addr  = r_b_op.addr;
        bin_wr.data  = (old_count == CountMax) ? old_count : old_count + CountW'(1);
    end

    sch_bin_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (adv),
        .i_rd_addr   (map_op.addr),
        .i_wr        (bin_wr),
        .o_old_count (old_count)
    );

    // new read result, or the held one while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (b_fire && r_b_op.is_read) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && r_b_op.is_read) begin
            r_bin_count <= r_b_op.upd ? old_count : '0;
            r_hist_size <= map_hist_size;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_count = r_bin_count;
    assign o_hist_size = r_hist_size;

endmodule

### hw/rtl/sch_checker.sv
module sch_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sch_pkg::CountW-1:0]    o_bin_count,
    input logic [7:0]                    o_hist_size
);
`include "spatial_code_histogram_macros.svh"

    // a stalled result holds
    `SCH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_bin_count) && $stable(o_hist_size))

    // the input side only backs up behind a stalled, full output
    `SCH_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // reset empties the output
    `SCH_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind spatial_code_histogram sch_checker u_sch_checker (.*);
